FILE: rtl/sst_pkg.sv
// Package: shared widths, status codes and controller/datapath interface types.
`default_nettype none

package sst_pkg;

    localparam int KEY_W    = 32;
    localparam int AMT_W    = 16;
    localparam int CNT_W    = 31;
    localparam int STAT_W   = 2;
    localparam int IDX_O_W  = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_INVALID   = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the request, rewind the scan
        logic issue;   // read one slot, advance the address
        logic finish;  // apply the update, register the result
    } t_sst_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_addr;  // scan address points at the final slot
    } t_sst_stat;

endpackage

`default_nettype wire

FILE: rtl/stacking_slot_table_core.sv
// Top level: slot table keeping a key and a saturating count per slot.
`default_nettype none

// Usage
//   Request channel: drive i_action, i_item_key and i_amount with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
//   Inputs are latched at that edge and need not be held afterwards.
//   Result channel: o_status, o_slot_index and o_new_count are valid for
//   exactly one cycle while o_done is high. The receiver cannot stall, so
//   capture the beat in that cycle.
// Timing
//   Every request scans all SLOTS entries through the single read port of
//   the slot memory, one entry a cycle, then does the last compare in the
//   drain state and the update in the finish state. busy is high through
//   scan, drain and finish, and o_done is registered from finish; a new
//   request may be taken in the cycle the result is shown, not before.
//   Rejected requests take the same time.
// Reset
//   Synchronous, active low. All slots read as empty at once after reset
//   (one valid flop per slot), so no clearing pass is needed; busy and
//   o_done are low.

module stacking_slot_table_core #(
    parameter int SLOTS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           i_action,
    input  wire  [sst_pkg::KEY_W-1:0]     i_item_key,
    input  wire  [sst_pkg::AMT_W-1:0]     i_amount,
    output logic                          o_done,
    output logic [sst_pkg::STAT_W-1:0]    o_status,
    output logic [sst_pkg::IDX_O_W-1:0]   o_slot_index,
    output logic [sst_pkg::CNT_W-1:0]     o_new_count
);
    import sst_pkg::*;

    t_sst_cmd  cmd;
    t_sst_stat stat;

    // Sequence each request: idle, scan, drain the read pipe, update.
    sst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold the slots, search for the key and the first free slot, apply
    // the add or remove and register the result beat.
    sst_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_item_key   (i_item_key),
        .i_amount     (i_amount),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_new_count  (o_new_count)
    );

endmodule

`default_nettype wire

FILE: rtl/sst_ctrl.sv
// Controller: request sequencing state machine for the slot table.
`default_nettype none

module sst_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  sst_pkg::t_sst_stat  i_stat,
    output sst_pkg::t_sst_cmd   o_cmd,
    output logic                o_busy
);
    import sst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not raise busy");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_busy)
        else $error("finish not followed by idle");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.issue, o_cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

FILE: rtl/sst_datapath.sv
// Datapath: slot memory, scan compare, update arithmetic and result registers.
`default_nettype none

module sst_datapath #(
    parameter int SLOTS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  sst_pkg::t_sst_cmd             i_cmd,
    output sst_pkg::t_sst_stat            o_stat,
    input  wire                           i_action,
    input  wire  [sst_pkg::KEY_W-1:0]     i_item_key,
    input  wire  [sst_pkg::AMT_W-1:0]     i_amount,
    output logic                          o_done,
    output logic [sst_pkg::STAT_W-1:0]    o_status,
    output logic [sst_pkg::IDX_O_W-1:0]   o_slot_index,
    output logic [sst_pkg::CNT_W-1:0]     o_new_count
);
    import sst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // slot store: key in the upper bits, count in the lower
    logic [KEY_W+CNT_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]       r_valid;

    logic                   r_action;
    logic [KEY_W-1:0]       r_key;
    logic [AMT_W-1:0]       r_amount;

    logic [IW-1:0]          r_addr;
    logic                   r_cmp_en;
    logic [IW-1:0]          r_cmp_idx;
    logic [KEY_W+CNT_W-1:0] r_rd_word;
    logic                   r_rd_vld;

    logic                   r_match;
    logic [IW-1:0]          r_match_idx;
    logic [CNT_W-1:0]       r_match_cnt;
    logic                   r_empty;
    logic [IW-1:0]          r_empty_idx;

    logic                   r_done;

    logic [KEY_W-1:0]       rd_key;
    logic [CNT_W-1:0]       rd_cnt;

    logic [CNT_W:0]         sum;
    logic [CNT_W-1:0]       sat_sum;
    logic                   wr_en;
    logic [IW-1:0]          wr_idx;
    logic [KEY_W-1:0]       wr_key;
    logic [CNT_W-1:0]       wr_cnt;
    t_status                res_status;
    logic [IW-1:0]          res_idx;
    logic [IW+IDX_O_W-1:0]  res_idx_ext;

    assign o_stat.last_addr = (r_addr == IW'(SLOTS - 1));

    // an entry never written reads as empty
    assign rd_key = r_rd_vld ? r_rd_word[KEY_W+CNT_W-1:CNT_W] : '0;
    assign rd_cnt = r_rd_vld ? r_rd_word[CNT_W-1:0] : '0;

    assign sum     = {1'b0, r_match_cnt} + (CNT_W+1)'(r_amount);
    assign sat_sum = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[CNT_W-1:0];

    always_comb begin
        wr_en      = 1'b0;
        wr_idx     = r_match_idx;
        wr_key     = r_key;
        wr_cnt     = '0;
        res_status = ST_INVALID;
        res_idx    = '0;
        priority if (r_key == '0 || r_amount == '0) begin
            res_status = ST_INVALID;
        end else if (!r_action) begin
            if (r_match) begin
                wr_en      = 1'b1;
                wr_cnt     = sat_sum;
                res_status = ST_DONE;
                res_idx    = r_match_idx;
            end else if (r_empty) begin
                wr_en      = 1'b1;
                wr_idx     = r_empty_idx;
                wr_cnt     = CNT_W'(r_amount);
                res_status = ST_DONE;
                res_idx    = r_empty_idx;
            end else begin
                res_status = ST_FULL;
            end
        end else begin
            if (r_match) begin
                wr_en      = 1'b1;
                res_status = ST_DONE;
                res_idx    = r_match_idx;
                if (r_match_cnt > CNT_W'(r_amount)) begin
                    wr_cnt = r_match_cnt - CNT_W'(r_amount);
                end else begin
                    wr_key = '0;
                    wr_cnt = '0;
                end
            end else begin
                res_status = ST_NOT_FOUND;
            end
        end
    end

    assign res_idx_ext = {{IDX_O_W{1'b0}}, res_idx};

    // memory port: one read per scan step, one write at finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_word <= mem[r_addr];
            r_rd_vld  <= r_valid[r_addr];
        end
        if (i_cmd.finish && wr_en) begin
            mem[wr_idx] <= {wr_key, wr_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish && wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // request latch and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_item_key;
            r_amount <= i_amount;
            r_addr   <= '0;
        end else if (i_cmd.issue) begin
            r_addr   <= r_addr + 1'b1;
        end
        if (i_cmd.issue) begin
            r_cmp_idx <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
            r_match  <= 1'b0;
            r_empty  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.issue;
            r_done   <= i_cmd.finish;
            if (i_cmd.load) begin
                r_match <= 1'b0;
                r_empty <= 1'b0;
            end else if (r_cmp_en) begin
                // keep the lowest index for both searches
                if (!r_match && rd_key == r_key) begin
                    r_match <= 1'b1;
                end
                if (!r_empty && rd_key == '0) begin
                    r_empty <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_en && !i_cmd.load) begin
            if (!r_match && rd_key == r_key) begin
                r_match_idx <= r_cmp_idx;
                r_match_cnt <= rd_cnt;
            end
            if (!r_empty && rd_key == '0) begin
                r_empty_idx <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status     <= res_status;
            o_slot_index <= res_idx_ext[IDX_O_W-1:0];
            o_new_count  <= wr_cnt;
        end
    end

    assign o_done = r_done;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_done)
        else $error("finish not followed by a result strobe");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_slot_index == '0 && o_new_count == '0))
        else $error("failed request returned a non-zero slot or count");

endmodule

`default_nettype wire

FILE: tb/stacking_slot_table_core_tb.sv
// Self-checking testbench for the stacking slot table core: queued requests, predicted results.
module stacking_slot_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int SLOTS      = 16;
    localparam int TAIL_ITEMS = 150;           // final stretch driven without idling
    localparam int DRAIN_CYC  = 3 * (SLOTS + 3);

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct {
        logic             action;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } t_slot_req;

    typedef struct {
        t_status            status;
        logic [IDX_O_W-1:0] slot;
        logic [CNT_W-1:0]   count;
    } t_slot_resp;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                i_action     = 1'b0;
    logic [KEY_W-1:0]    i_item_key   = '0;
    logic [AMT_W-1:0]    i_amount     = '0;
    logic                busy;
    logic                o_done;
    logic [STAT_W-1:0]   o_status;
    logic [IDX_O_W-1:0]  o_slot_index;
    logic [CNT_W-1:0]    o_new_count;

    // Requests waiting to be driven, and results the table must still return
    t_slot_req  pending_reqs[$];
    t_slot_resp expected_resps[$];

    // Shadow copy of the slot table
    logic [KEY_W-1:0] table_keys   [SLOTS];
    logic [CNT_W-1:0] table_counts [SLOTS];

    // Driver state
    t_slot_req cur_req;
    logic      have_cur  = 1'b0;
    logic      idle_on   = 1'b1;
    int        gap_left  = 0;
    int        error_count = 0;

    stacking_slot_table_core #(
        .SLOTS        (SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_item_key   (i_item_key),
        .i_amount     (i_amount),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_new_count  (o_new_count)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Work out the result of one request and update the shadow table.
    // Lowest matching slot wins; a new key goes into the lowest empty slot.
    function automatic t_slot_resp predict_table_update(t_slot_req req);
        t_slot_resp  resp;
        int          hit;
        int          free_slot;
        logic [31:0] sum;
        resp.status = ST_INVALID;
        resp.slot   = '0;
        resp.count  = '0;
        hit         = -1;
        free_slot   = -1;
        // Key zero or amount zero: reject, leave the table alone
        if (req.key == '0 || req.amount == '0)
            return resp;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && table_keys[i] == req.key)
                hit = i;
            if (free_slot < 0 && table_keys[i] == '0)
                free_slot = i;
        end
        if (req.action == ACT_ADD) begin
            if (hit >= 0) begin
                // Saturate at the count maximum
                sum = {1'b0, table_counts[hit]} + {16'd0, req.amount};
                table_counts[hit] = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[CNT_W-1:0];
                resp.status = ST_DONE;
                resp.slot   = hit[IDX_O_W-1:0];
                resp.count  = table_counts[hit];
            end else if (free_slot < 0) begin
                resp.status = ST_FULL;
            end else begin
                table_keys[free_slot]   = req.key;
                table_counts[free_slot] = {15'd0, req.amount};
                resp.status = ST_DONE;
                resp.slot   = free_slot[IDX_O_W-1:0];
                resp.count  = table_counts[free_slot];
            end
        end else begin
            if (hit < 0) begin
                resp.status = ST_NOT_FOUND;
            end else begin
                // Free the slot once the amount covers the whole count
                if (table_counts[hit] > {15'd0, req.amount}) begin
                    table_counts[hit] = table_counts[hit] - {15'd0, req.amount};
                end else begin
                    table_counts[hit] = '0;
                    table_keys[hit]   = '0;
                end
                resp.status = ST_DONE;
                resp.slot   = hit[IDX_O_W-1:0];
                resp.count  = table_counts[hit];
            end
        end
        return resp;
    endfunction

    function automatic logic [KEY_W-1:0] fill_key(int i);
        logic [KEY_W-1:0] k;
        k = 32'h0101_0101 * (i + 1);
        if (i % 2 == 1)
            k = k ^ 32'hF000_0000;
        return k;
    endfunction

    task automatic queue_req(logic action, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amount);
        t_slot_req req;
        req.action = action;
        req.key    = key;
        req.amount = amount;
        pending_reqs.push_back(req);
    endtask

    // Request driver: hold start with the current beat until the table takes it,
    // dropping start for short random bursts that may land on any phase of a scan.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_resps.push_back(predict_table_update(cur_req));
                have_cur = 1'b0;
                // Flip between idling and clean stretches now and then
                if ($urandom_range(0, 9) == 0)
                    idle_on = !idle_on;
            end
            if (!have_cur && pending_reqs.size() != 0) begin
                cur_req  = pending_reqs.pop_front();
                have_cur = 1'b1;
                i_action   <= cur_req.action;
                i_item_key <= cur_req.key;
                i_amount   <= cur_req.amount;
            end
            // No idling in the tail of the run
            if (gap_left == 0 && idle_on && pending_reqs.size() >= TAIL_ITEMS &&
                $urandom_range(0, 15) == 0)
                gap_left = $urandom_range(1, 5);
            if (gap_left != 0) begin
                start <= 1'b0;
                gap_left--;
            end else begin
                start <= have_cur;
            end
        end
    end

    // Result monitor: every done beat must match the oldest prediction
    always @(posedge i_clk) begin
        t_slot_resp exp_resp;
        if (i_rst_n && o_done) begin
            if (expected_resps.size() == 0) begin
                $error("result beat with no request outstanding: status %0d slot %0d count %0d",
                       o_status, o_slot_index, o_new_count);
                error_count++;
            end else begin
                exp_resp = expected_resps.pop_front();
                if (o_status !== exp_resp.status) begin
                    $error("status: expected %0d, actual %0d", exp_resp.status, o_status);
                    error_count++;
                end
                if (o_slot_index !== exp_resp.slot) begin
                    $error("slot_index: expected %0d, actual %0d", exp_resp.slot, o_slot_index);
                    error_count++;
                end
                if (o_new_count !== exp_resp.count) begin
                    $error("new_count: expected %0d, actual %0d", exp_resp.count, o_new_count);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [KEY_W-1:0] key_pool[24];
        logic [AMT_W-1:0] amt;
        int               pick;

        for (int i = 0; i < SLOTS; i++) begin
            table_keys[i]   = '0;
            table_counts[i] = '0;
        end

        // Directed: rejects, absent key, extremes, partial and over-size removal
        queue_req(ACT_ADD,    32'h0000_0000, 16'h0005);
        queue_req(ACT_REMOVE, 32'h0000_0005, 16'h0000);
        queue_req(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_req(ACT_ADD,    32'hFFFF_FFFF, 16'hFFFF);
        queue_req(ACT_REMOVE, 32'hFFFF_FFFF, 16'h0001);
        queue_req(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        // Fill every slot, then overflow the table
        for (int i = 0; i < SLOTS; i++)
            queue_req(ACT_ADD, fill_key(i), 16'(i + 1));
        queue_req(ACT_ADD, 32'h8000_0000, 16'h0001);
        // Remove exactly the count of a middle slot, then reuse the hole
        queue_req(ACT_REMOVE, fill_key(9), 16'd10);
        queue_req(ACT_ADD, 32'h8000_0000, 16'h7FFF);

        // Free the first slot with an over-size removal, then miss it
        queue_req(ACT_REMOVE, fill_key(0), 16'hFFFF);
        queue_req(ACT_REMOVE, fill_key(0), 16'hFFFF);

        // Random: mostly add and remove on a pool a bit larger than the table,
        // so hits, fills, frees and full-table rejects all keep happening
        for (int i = 0; i < 24; i++)
            key_pool[i] = (i < SLOTS) ? fill_key(i) : ($urandom() | 32'h1);
        for (int n = 0; n < 1525; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       amt = 16'($urandom_range(1, 20));
                1:       amt = 16'($urandom_range(1, 16'hFFFF));
                default: amt = 16'($urandom());
            endcase
            if (pick < 4) begin
                if ($urandom_range(0, 1) == 0)
                    queue_req(1'($urandom()), '0, amt);
                else
                    queue_req(1'($urandom()), $urandom(), '0);
            end else if (pick < 12) begin
                queue_req(1'($urandom()), $urandom(), amt);
            end else if (pick < 60) begin
                queue_req(ACT_ADD, key_pool[$urandom_range(0, 23)], amt);
            end else begin
                queue_req(ACT_REMOVE, key_pool[$urandom_range(0, 23)], amt);
            end
        end

        // Hold reset, then release it on an edge
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to go in and every result to come back
        do
            @(posedge i_clk);
        while (pending_reqs.size() != 0 || have_cur || start || expected_resps.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
